FILE: sv/gftc_pkg.sv
// Package with shared types and constants for the gated four-channel timer.
`timescale 1ns / 1ps
package gftc_pkg;

   // Timer counts and compare values.
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Timers that have mode and compare registers, and timers shown on the result.
   localparam int REG_TIMERS = 4;
   localparam int OUT_TIMERS = 4;
   localparam int TIMER_COUNT_DEFAULT = 4;

   // Configuration port.
   localparam int MODE_W = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_MODE_BASE = 0;
   localparam int CSR_COMPARE_BASE = 4;

   // Clock event kinds.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] CLK_BUS = 2'd0;
   localparam logic [KIND_W-1:0] CLK_BUS16 = 2'd1;
   localparam logic [KIND_W-1:0] CLK_BUS256 = 2'd2;
   localparam logic [KIND_W-1:0] CLK_HBLANK = 2'd3;

   // Gate select and gate modes.
   localparam logic GATE_SEL_HBLANK = 1'b0;
   localparam logic GATE_SEL_VBLANK = 1'b1;
   localparam logic [1:0] GATE_MODE_LEVEL = 2'd0;
   localparam logic [1:0] GATE_MODE_RISE = 2'd1;
   localparam logic [1:0] GATE_MODE_FALL = 2'd2;
   localparam logic [1:0] GATE_MODE_BOTH = 2'd3;

   // Bit positions within a mode word.
   localparam int MODE_CLKSEL_LO = 0;
   localparam int MODE_GATE = 2;
   localparam int MODE_GATESEL = 3;
   localparam int MODE_GATEMODE_LO = 4;
   localparam int MODE_ZRET = 6;
   localparam int MODE_ENABLE = 7;
   localparam int MODE_CMPIRQ = 8;
   localparam int MODE_OVFIRQ = 9;

   // One clock event as seen by every timer. Index 0 of the level pairs is
   // hblank, index 1 is vblank.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [1:0]        lvl_now;
      logic [1:0]        lvl_before;
   } gate_evt_type;

endpackage

FILE: sv/gftc_timer.sv
// One timer channel: mode and compare registers, count register and its update.
`timescale 1ns / 1ps
module gftc_timer
   import gftc_pkg::*;
#(
   parameter int TIMER_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  gate_evt_type           evt,
   input  logic                   update,
   output logic [COUNT_W-1:0]     count_after,
   output logic                   irq
);

   localparam logic [CSR_INDEX_W-1:0] MODE_ADDR =
      CSR_INDEX_W'(CSR_MODE_BASE + TIMER_INDEX);
   localparam logic [CSR_INDEX_W-1:0] COMPARE_ADDR =
      CSR_INDEX_W'(CSR_COMPARE_BASE + TIMER_INDEX);

   logic [MODE_W-1:0]  mode_ff;
   logic [COUNT_W-1:0] compare_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic [1:0]         clksel;
   logic               gsel;
   logic [1:0]         gmode;
   logic               hit;
   logic               gate_on;
   logic               lvl_now;
   logic               lvl_was;
   logic               rise;
   logic               fall;
   logic               gate_clear;
   logic               count_it;
   logic [COUNT_W-1:0] base;
   logic [COUNT_W:0]   incr;
   logic [COUNT_W-1:0] stepped;
   logic               overflow;
   logic               reached;

   always_comb begin
      clksel  = mode_ff[MODE_CLKSEL_LO +: 2];
      gsel    = mode_ff[MODE_GATESEL];
      gmode   = mode_ff[MODE_GATEMODE_LO +: 2];
      hit     = mode_ff[MODE_ENABLE] && (clksel == evt.kind);
      // Gating is ignored when both the clock and the gate are hblank.
      gate_on = mode_ff[MODE_GATE] &&
                !((clksel == CLK_HBLANK) && (gsel == GATE_SEL_HBLANK));
      lvl_now = evt.lvl_now[gsel];
      lvl_was = evt.lvl_before[gsel];
      rise    = lvl_now && !lvl_was;
      fall    = !lvl_now && lvl_was;

      gate_clear = gate_on && (((gmode == GATE_MODE_RISE) && rise) ||
                               ((gmode == GATE_MODE_FALL) && fall) ||
                               ((gmode == GATE_MODE_BOTH) && (rise || fall)));
      count_it   = !(gate_on && (gmode == GATE_MODE_LEVEL) && lvl_now);

      base = gate_clear ? '0 : count_ff;
      incr = {1'b0, base} + {{COUNT_W{1'b0}}, 1'b1};
      if (count_it) begin
         stepped  = incr[COUNT_W-1:0];
         overflow = (base == COUNT_MAX);
      end else begin
         stepped  = base;
         overflow = 1'b0;
      end

      reached = (stepped >= compare_ff);
      irq     = hit && ((mode_ff[MODE_CMPIRQ] && reached) ||
                        (mode_ff[MODE_OVFIRQ] && overflow));

      if (!hit) begin
         count_in = count_ff;
      end else if (mode_ff[MODE_ZRET] && reached) begin
         count_in = '0;
      end else begin
         count_in = stepped;
      end
      count_after = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         compare_ff <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_write_enable && (csr_index == MODE_ADDR)) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end
         if (csr_write_enable && (csr_index == COMPARE_ADDR)) begin
            compare_ff <= csr_wdata[COUNT_W-1:0];
         end
         if (update) begin
            count_ff <= count_in;
         end
      end
   end

endmodule

FILE: sv/gated_four_channel_timer_core.sv
// Top level of the gated four-channel timer: input register, timers, result register.
`timescale 1ns / 1ps
//
//   Port group  Direction  Handshake                  Payload
//   req_*       in         req_valid / req_stall      req_mode, hblank/vblank levels
//   rsp_*       out        rsp_valid / rsp_stall      rsp_irq_mask, rsp_count_out0..3
//   csr_*       in         csr_write_enable           csr_index, csr_wdata
//
// Each item passes through the input register and then the result register, which
// drives the rsp ports; both hold their items while the result side stalls.
// The timers update their counts combinationally from the input register, so
// one item is taken in every cycle while the result side keeps up.
// A stalled result holds in the result register while one further item waits
// in the input register; only then does req_stall rise.
// Reset is synchronous and clears the counts, the mode and compare registers
// and both valid flags.
module gated_four_channel_timer_core
   import gftc_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_mode,
   input  logic                   req_hblank_now,
   input  logic                   req_vblank_now,
   input  logic                   req_hblank_before,
   input  logic                   req_vblank_before,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_TIMERS-1:0]  rsp_irq_mask,
   output logic [COUNT_W-1:0]     rsp_count_out0,
   output logic [COUNT_W-1:0]     rsp_count_out1,
   output logic [COUNT_W-1:0]     rsp_count_out2,
   output logic [COUNT_W-1:0]     rsp_count_out3,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Only timers that have registers, up to TIMER_COUNT, exist in hardware; any
   // other result slots stay at zero with no interrupt.
   localparam int ACTIVE_TIMERS = (TIMER_COUNT < REG_TIMERS) ? TIMER_COUNT : REG_TIMERS;

   // Input register.
   logic         in_valid_ff;
   logic         in_valid_in;
   gate_evt_type in_evt_ff;
   gate_evt_type req_evt;

   // Result register.
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [OUT_TIMERS-1:0] out_irq_ff;
   logic [COUNT_W-1:0]    out_count_ff [OUT_TIMERS];

   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   logic [OUT_TIMERS-1:0] irq_vec;
   logic [COUNT_W-1:0]    count_vec [OUT_TIMERS];

   // The result register can load when empty or when its item leaves now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   // The item in the input register moves on and updates the counts.
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign req_evt.kind       = req_mode;
   assign req_evt.lvl_now    = {req_vblank_now, req_hblank_now};
   assign req_evt.lvl_before = {req_vblank_before, req_hblank_before};

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   genvar gi;
   generate
      for (gi = 0; gi < OUT_TIMERS; gi++) begin : g_timer
         if (gi < ACTIVE_TIMERS) begin : g_live
            gftc_timer #(
               .TIMER_INDEX (gi)
            ) u_timer (
               .clock            (clock),
               .reset            (reset),
               .csr_write_enable (csr_write_enable),
               .csr_index        (csr_index),
               .csr_wdata        (csr_wdata),
               .evt              (in_evt_ff),
               .update           (advance),
               .count_after      (count_vec[gi]),
               .irq              (irq_vec[gi])
            );
         end else begin : g_absent
            assign count_vec[gi] = '0;
            assign irq_vec[gi]   = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_evt_ff <= req_evt;
      end
      if (advance) begin
         out_irq_ff <= irq_vec;
         for (int i = 0; i < OUT_TIMERS; i++) begin
            out_count_ff[i] <= count_vec[i];
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_irq_mask   = out_irq_ff;
   assign rsp_count_out0 = out_count_ff[0];
   assign rsp_count_out1 = out_count_ff[1];
   assign rsp_count_out2 = out_count_ff[2];
   assign rsp_count_out3 = out_count_ff[3];

endmodule

FILE: dv/timer_count_checker.sv
// Checker that predicts the four timer counts and compares every result item.
`timescale 1ns / 1ps
module timer_count_checker
   import gftc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [KIND_W-1:0]      req_mode,
   input  logic                   req_hblank_now,
   input  logic                   req_vblank_now,
   input  logic                   req_hblank_before,
   input  logic                   req_vblank_before,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [OUT_TIMERS-1:0]  rsp_irq_mask,
   input  logic [COUNT_W-1:0]     rsp_count_out0,
   input  logic [COUNT_W-1:0]     rsp_count_out1,
   input  logic [COUNT_W-1:0]     rsp_count_out2,
   input  logic [COUNT_W-1:0]     rsp_count_out3,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     pending,
   output int                     mismatches
);

   typedef struct packed {
      logic [OUT_TIMERS-1:0]              irq_mask;
      logic [OUT_TIMERS-1:0][COUNT_W-1:0] counts;
   } timer_snapshot_type;

   logic [MODE_W-1:0]  mode_q    [REG_TIMERS];
   logic [COUNT_W-1:0] compare_q [REG_TIMERS];
   logic [COUNT_W-1:0] count_q   [REG_TIMERS];
   timer_snapshot_type expected_counts_q [$];
   int                 fail_count;

   assign mismatches = fail_count;

   // Advances each enabled timer whose clock matches the event; returns the flags and counts.
   function automatic timer_snapshot_type step_timers(gate_evt_type ev);
      timer_snapshot_type snap;
      logic [MODE_W-1:0]  m;
      logic [COUNT_W-1:0] cnt;
      logic               gsel, now, was, rise, fall, run, wrapped, hit;
      snap = '0;
      for (int t = 0; t < REG_TIMERS; t++) begin
         m = mode_q[t];
         cnt = count_q[t];
         if (m[MODE_ENABLE] && m[MODE_CLKSEL_LO +: 2] == ev.kind) begin
            gsel = m[MODE_GATESEL];
            run = 1'b1;
            wrapped = 1'b0;
            // An hblank clock gated by hblank itself runs ungated.
            if (m[MODE_GATE] && !(ev.kind == CLK_HBLANK && gsel == GATE_SEL_HBLANK)) begin
               now = ev.lvl_now[gsel];
               was = ev.lvl_before[gsel];
               rise = now & ~was;
               fall = ~now & was;
               case (m[MODE_GATEMODE_LO +: 2])
                  GATE_MODE_LEVEL: run = ~now;
                  GATE_MODE_RISE: if (rise) cnt = '0;
                  GATE_MODE_FALL: if (fall) cnt = '0;
                  GATE_MODE_BOTH: if (rise | fall) cnt = '0;
                  default: ;
               endcase
            end
            if (run) begin
               if (cnt == COUNT_MAX) begin
                  cnt = '0;
                  wrapped = 1'b1;
               end else begin
                  cnt = cnt + COUNT_W'(1);
               end
            end
            hit = (cnt >= compare_q[t]);
            snap.irq_mask[t] = (m[MODE_CMPIRQ] & hit) | (m[MODE_OVFIRQ] & wrapped);
            if (m[MODE_ZRET] && hit) cnt = '0;
            count_q[t] = cnt;
         end
         snap.counts[t] = count_q[t];
      end
      return snap;
   endfunction

   always @(posedge clock) begin
      timer_snapshot_type seen, want;
      gate_evt_type       ev;
      if (reset) begin
         for (int t = 0; t < REG_TIMERS; t++) begin
            mode_q[t] = '0;
            compare_q[t] = '0;
            count_q[t] = '0;
         end
         expected_counts_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.irq_mask = rsp_irq_mask;
            seen.counts[0] = rsp_count_out0;
            seen.counts[1] = rsp_count_out1;
            seen.counts[2] = rsp_count_out2;
            seen.counts[3] = rsp_count_out3;
            if (expected_counts_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result item with none expected: irq %h counts %h",
                           $realtime, seen.irq_mask, seen.counts);
            end else begin
               want = expected_counts_q.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: irq exp %h got %h, counts exp %h got %h",
                              $realtime, want.irq_mask, seen.irq_mask,
                              want.counts, seen.counts);
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index < CSR_COMPARE_BASE)
               mode_q[csr_index - CSR_MODE_BASE] = csr_wdata[MODE_W-1:0];
            else if (csr_index < CSR_COMPARE_BASE + REG_TIMERS)
               compare_q[csr_index - CSR_COMPARE_BASE] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            ev.kind = req_mode;
            ev.lvl_now = {req_vblank_now, req_hblank_now};
            ev.lvl_before = {req_vblank_before, req_hblank_before};
            expected_counts_q.push_back(step_timers(ev));
         end
      end
      pending <= expected_counts_q.size();
   end

endmodule

FILE: dv/testbench.sv
// Top of the timer testbench: clock, reset, stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module testbench;
   import gftc_pkg::*;

   // Indexes at and above this one address no register and must be ignored.
   localparam int CSR_FIRST_UNUSED = CSR_COMPARE_BASE + REG_TIMERS;
   localparam int CSR_LAST_INDEX = (1 << CSR_INDEX_W) - 1;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 110;
   // Length of the stretch of bus clock events sent back to back.
   localparam int BURST_ITEMS = 100;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_mode = CLK_BUS;
   logic                   req_hblank_now = 1'b0;
   logic                   req_vblank_now = 1'b0;
   logic                   req_hblank_before = 1'b0;
   logic                   req_vblank_before = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [OUT_TIMERS-1:0]  rsp_irq_mask;
   logic [COUNT_W-1:0]     rsp_count_out0;
   logic [COUNT_W-1:0]     rsp_count_out1;
   logic [COUNT_W-1:0]     rsp_count_out2;
   logic [COUNT_W-1:0]     rsp_count_out3;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   pending;
   int   mismatches;

   // Result-side stall control: rsp_idle_on enables random stalls, rsp_taken
   // remembers that the previous rising edge accepted a result item.
   logic rsp_idle_on = 1'b1;
   logic rsp_taken = 1'b0;
   int   stall_left = 0;

   // Running video signal levels, so that most events form a plausible
   // sequence in which each previous level equals the last current level.
   logic hblank_level = 1'b0;
   logic vblank_level = 1'b0;

   always #4 clock = ~clock;

   gated_four_channel_timer_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_hblank_now    (req_hblank_now),
      .req_vblank_now    (req_vblank_now),
      .req_hblank_before (req_hblank_before),
      .req_vblank_before (req_vblank_before),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_irq_mask      (rsp_irq_mask),
      .rsp_count_out0    (rsp_count_out0),
      .rsp_count_out1    (rsp_count_out1),
      .rsp_count_out2    (rsp_count_out2),
      .rsp_count_out3    (rsp_count_out3),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   timer_count_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_hblank_now    (req_hblank_now),
      .req_vblank_now    (req_vblank_now),
      .req_hblank_before (req_hblank_before),
      .req_vblank_before (req_vblank_before),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_irq_mask      (rsp_irq_mask),
      .rsp_count_out0    (rsp_count_out0),
      .rsp_count_out1    (rsp_count_out1),
      .rsp_count_out2    (rsp_count_out2),
      .rsp_count_out3    (rsp_count_out3),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .pending           (pending),
      .mismatches        (mismatches)
   );

   // The receiver draws a fresh stall length after every accepted result item.
   // The flag is captured at the rising edge and used at the next falling edge,
   // where all inputs of the block change.
   always @(posedge clock) begin
      rsp_taken <= rsp_valid && !rsp_stall;
   end

   always @(negedge clock) begin
      if (rsp_taken) stall_left = rsp_idle_on ? $urandom_range(0, 9) : 0;
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // Packs the fields of a mode word in the layout of the mode registers.
   function automatic logic [CSR_DATA_W-1:0] make_mode(logic [1:0] clksel, logic gate,
                                                        logic gatesel, logic [1:0] gmode,
                                                        logic zret, logic enable,
                                                        logic cmpirq, logic ovfirq);
      logic [CSR_DATA_W-1:0] w;
      w = '0;
      w[MODE_CLKSEL_LO +: 2] = clksel;
      w[MODE_GATE] = gate;
      w[MODE_GATESEL] = gatesel;
      w[MODE_GATEMODE_LO +: 2] = gmode;
      w[MODE_ZRET] = zret;
      w[MODE_ENABLE] = enable;
      w[MODE_CMPIRQ] = cmpirq;
      w[MODE_OVFIRQ] = ovfirq;
      return w;
   endfunction

   // Produces the next clock event. Most events follow the running video
   // levels; about one in five carries arbitrary levels as noise.
   function automatic gate_evt_type next_video_event();
      gate_evt_type ev;
      ev.kind = KIND_W'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
         ev.lvl_now = 2'($urandom_range(0, 3));
         ev.lvl_before = 2'($urandom_range(0, 3));
      end else begin
         ev.lvl_before = {vblank_level, hblank_level};
         if ($urandom_range(0, 3) == 0) hblank_level = ~hblank_level;
         if ($urandom_range(0, 7) == 0) vblank_level = ~vblank_level;
         ev.lvl_now = {vblank_level, hblank_level};
      end
      return ev;
   endfunction

   // Writes one register. The caller lowers the write enable after its last
   // write, so the enable is never dropped and raised within one time step.
   task automatic write_reg(input int index, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_INDEX_W'(index);
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Offers one item after an idle gap and returns at the falling edge that
   // follows its acceptance. Called at a falling edge.
   task automatic send_event(input gate_evt_type ev, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= ev.kind;
      req_hblank_now <= ev.lvl_now[0];
      req_vblank_now <= ev.lvl_now[1];
      req_hblank_before <= ev.lvl_before[0];
      req_vblank_before <= ev.lvl_before[1];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted result item has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Hard limit on the run. The slowest correct run is well under a millisecond.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      gate_evt_type         ev;
      logic [3:0]           pattern;
      logic                 sender_idle;
      logic [CSR_DATA_W-1:0] word;
      // Level patterns as {now, before} with hblank in the low bit of each
      // pair: quiet, both high, hblank rise, hblank fall, vblank rise, vblank fall.
      logic [3:0]           level_patterns [6];
      level_patterns = '{4'b0000, 4'b1111, 4'b0100, 4'b0001, 4'b1000, 4'b0010};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Timer 0 counts bus clocks and returns to zero at 3.
      // Timer 1 is gated by the hblank level with a compare of zero, so it
      // skips ticks while hblank is high and always stays at zero. Timer 2
      // is cleared by a vblank rise and compares against the largest value.
      // Timer 3 counts hblank events with hblank gating, which is ignored.
      // Two writes to unused indexes must change nothing.
      write_reg(CSR_MODE_BASE + 0, make_mode(CLK_BUS, 1'b0, GATE_SEL_HBLANK,
                GATE_MODE_LEVEL, 1'b1, 1'b1, 1'b1, 1'b0));
      write_reg(CSR_MODE_BASE + 1, make_mode(CLK_BUS16, 1'b1, GATE_SEL_HBLANK,
                GATE_MODE_LEVEL, 1'b1, 1'b1, 1'b1, 1'b0));
      write_reg(CSR_MODE_BASE + 2, make_mode(CLK_BUS256, 1'b1, GATE_SEL_VBLANK,
                GATE_MODE_RISE, 1'b0, 1'b1, 1'b1, 1'b1));
      write_reg(CSR_MODE_BASE + 3, make_mode(CLK_HBLANK, 1'b1, GATE_SEL_HBLANK,
                GATE_MODE_BOTH, 1'b0, 1'b1, 1'b1, 1'b0));
      write_reg(CSR_COMPARE_BASE + 0, 16'd3);
      write_reg(CSR_COMPARE_BASE + 1, 16'd0);
      write_reg(CSR_COMPARE_BASE + 2, COUNT_MAX);
      write_reg(CSR_COMPARE_BASE + 3, 16'd2);
      write_reg(CSR_FIRST_UNUSED, 16'hFFFF);
      write_reg(CSR_LAST_INDEX, 16'h5A5A);
      csr_write_enable <= 1'b0;

      // Every event kind with every edge and level combination of interest.
      for (int k = 0; k < 4; k++) begin
         for (int p = 0; p < 6; p++) begin
            pattern = level_patterns[p];
            ev.kind = KIND_W'(k);
            ev.lvl_now = pattern[3:2];
            ev.lvl_before = pattern[1:0];
            send_event(ev, $urandom_range(0, 9));
         end
      end
      wait_drained();

      // Burst run: all timers count bus clocks back to back with no stalls on
      // either side. Timers 0 and 1 run free, timer 2 counts only while
      // vblank is low and timer 3 clears on an hblank rise.
      rsp_idle_on <= 1'b0;
      write_reg(CSR_MODE_BASE + 0, make_mode(CLK_BUS, 1'b0, GATE_SEL_HBLANK,
                GATE_MODE_LEVEL, 1'b0, 1'b1, 1'b0, 1'b1));
      write_reg(CSR_MODE_BASE + 1, make_mode(CLK_BUS, 1'b0, GATE_SEL_HBLANK,
                GATE_MODE_LEVEL, 1'b0, 1'b1, 1'b1, 1'b1));
      write_reg(CSR_MODE_BASE + 2, make_mode(CLK_BUS, 1'b1, GATE_SEL_VBLANK,
                GATE_MODE_LEVEL, 1'b0, 1'b1, 1'b0, 1'b1));
      write_reg(CSR_MODE_BASE + 3, make_mode(CLK_BUS, 1'b1, GATE_SEL_HBLANK,
                GATE_MODE_RISE, 1'b0, 1'b1, 1'b1, 1'b1));
      write_reg(CSR_COMPARE_BASE + 0, 16'd0);
      write_reg(CSR_COMPARE_BASE + 1, COUNT_MAX);
      write_reg(CSR_COMPARE_BASE + 3, 16'h8000);
      csr_write_enable <= 1'b0;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         ev = next_video_event();
         ev.kind = CLK_BUS;
         send_event(ev, 0);
      end
      wait_drained();

      // Random phases. The first sets every register to all ones and the
      // second to all zeros; the rest draw mode words that are mostly enabled
      // and compare values that are mostly small, so matches happen often.
      // Idling on either side is switched off in some phases to give long
      // back-to-back stretches.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         sender_idle = (ph % 4 != 3);
         rsp_idle_on <= (ph % 4 != 2);
         for (int t = 0; t < REG_TIMERS; t++) begin
            if (ph == 0) word = 16'hFFFF;
            else if (ph == 1) word = '0;
            else begin
               word = CSR_DATA_W'($urandom);
               if ($urandom_range(0, 4) != 0) word[MODE_ENABLE] = 1'b1;
            end
            write_reg(CSR_MODE_BASE + t, word);
            if (ph == 0) word = COUNT_MAX;
            else if (ph == 1) word = '0;
            else begin
               case ($urandom_range(0, 5))
                  0: word = '0;
                  1: word = COUNT_MAX;
                  2: word = CSR_DATA_W'($urandom);
                  default: word = CSR_DATA_W'($urandom_range(1, 40));
               endcase
            end
            write_reg(CSR_COMPARE_BASE + t, word);
         end
         write_reg($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX), CSR_DATA_W'($urandom));
         csr_write_enable <= 1'b0;

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Halfway through, hold off until the block has emptied.
            if (i == ITEMS_PER_PHASE / 2) wait_drained();
            send_event(next_video_event(), sender_idle ? $urandom_range(0, 9) : 0);
         end
         wait_drained();
      end

      // Wait before the verdict so that any stray result item can show up.
      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/gftc_pkg.sv
sv/gftc_timer.sv
sv/gated_four_channel_timer_core.sv
dv/timer_count_checker.sv
dv/testbench.sv
